[hdl/joystick_frame_drive_mapper_macros.svh]
// assertion macros used by the joystick frame drive mapper top level
`ifndef JOYSTICK_FRAME_DRIVE_MAPPER_MACROS_SVH
`define JOYSTICK_FRAME_DRIVE_MAPPER_MACROS_SVH

// same-cycle implication, checked outside reset
`define JFDM_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define JFDM_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/jfdm_pkg.sv]
// shared types, constants and codes of the joystick frame drive mapper
package jfdm_pkg;

    // default frame limits
    localparam int DEF_MAX_DIGITS = 3;
    localparam int DEF_LINE_LIMIT = 11;

    // payload widths
    localparam int BYTE_W  = 8;
    localparam int LEVEL_W = 7;
    localparam int MAG_W   = 10;
    localparam int PROD_W  = 14;
    localparam int SVAL_W  = 12;
    localparam int DIGIT_W = 4;
    localparam int OUT_W   = 24;
    localparam int CFG_AW  = 1;

    // value limits
    localparam logic [MAG_W-1:0]   MAG_LIMIT   = 10'd1023;
    localparam logic [MAG_W-1:0]   BRAKE_VALUE = 10'd100;
    localparam logic [LEVEL_W-1:0] LEVEL_RESET = 7'd70;

    // queue between parser and mapper
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // characters
    localparam logic [BYTE_W-1:0] CH_X     = 8'h58;
    localparam logic [BYTE_W-1:0] CH_Y     = 8'h59;
    localparam logic [BYTE_W-1:0] CH_SEMI  = 8'h3B;
    localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

    // configuration register indexes
    localparam logic [CFG_AW-1:0] CFG_LEFT_LEVEL  = 1'd0;
    localparam logic [CFG_AW-1:0] CFG_RIGHT_LEVEL = 1'd1;

    // parser phases
    typedef enum logic [2:0] {
        PH_EXPECT_X,
        PH_X_SEP,
        PH_X_FIRST,
        PH_X_DIGITS,
        PH_Y_SEP,
        PH_Y_FIRST,
        PH_Y_DIGITS
    } t_phase;

    // one parsed frame handed from parser to mapper
    typedef struct packed {
        logic             valid;
        logic             x_neg;
        logic [MAG_W-1:0] x_mag;
        logic             y_neg;
        logic [MAG_W-1:0] y_mag;
    } t_frame_rec;

    // queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // one result item
    typedef struct packed {
        logic               brake_request;
        logic               toggle_direction;
        logic               direction_backward;
        logic [LEVEL_W-1:0] right_drive;
        logic [LEVEL_W-1:0] left_drive;
        logic               frame_valid;
    } t_result;

endpackage

[hdl/jfdm_front.sv]
// byte parser: takes frame bytes, builds x and y, pushes one record per ';'
module jfdm_front
    import jfdm_pkg::*;
#(
    parameter int MAX_DIGITS = DEF_MAX_DIGITS,
    parameter int LINE_LIMIT = DEF_LINE_LIMIT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_byte_valid,
    input  logic [BYTE_W-1:0] i_byte,
    input  t_q_status         i_q_status,
    output logic              o_byte_ready,
    output logic              o_push,
    output t_frame_rec        o_rec
);

    localparam int POS_W  = $clog2(LINE_LIMIT + 1);
    localparam int DCNT_W = $clog2(MAX_DIGITS + 2);
    localparam logic [POS_W-1:0]  POS_LIMIT = POS_W'(LINE_LIMIT);
    localparam logic [DCNT_W-1:0] DCNT_MAX  = DCNT_W'(MAX_DIGITS);

    t_phase             r_phase, n_phase;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic [DCNT_W-1:0]  r_dcnt, n_dcnt;
    logic               r_neg, n_neg;
    logic               r_x_neg, n_x_neg;
    logic [MAG_W-1:0]   r_x_mag, n_x_mag;
    logic [MAG_W-1:0]   r_y_mag, n_y_mag;
    logic               r_err, n_err;

    logic               w_accept;
    logic               w_is_end;
    logic               w_is_ctrl;
    logic               w_is_digit;
    logic [DIGIT_W-1:0] w_digit;
    logic               w_in_y;
    logic [MAG_W-1:0]   w_cur_mag;
    logic [DCNT_W-1:0]  w_dcnt_inc;
    logic               w_too_many;
    logic [PROD_W-1:0]  w_mag10;
    logic [MAG_W-1:0]   w_mag_new;

    // byte classification
    assign w_accept   = i_byte_valid && o_byte_ready;
    assign w_is_end   = (i_byte == CH_SEMI);
    assign w_is_ctrl  = (i_byte == CH_CR) || (i_byte == CH_LF);
    assign w_is_digit = i_byte inside {[CH_ZERO:CH_NINE]};
    assign w_digit    = i_byte[DIGIT_W-1:0];

    // digit accumulation, magnitude saturates
    assign w_in_y     = (r_phase == PH_Y_FIRST) || (r_phase == PH_Y_DIGITS);
    assign w_cur_mag  = w_in_y ? r_y_mag : r_x_mag;
    assign w_dcnt_inc = (r_dcnt <= DCNT_MAX) ? r_dcnt + 1'b1 : r_dcnt;
    assign w_too_many = (w_dcnt_inc > DCNT_MAX);
    assign w_mag10    = {1'b0, w_cur_mag, 3'b000} + {3'b000, w_cur_mag, 1'b0}
                      + {{(PROD_W-DIGIT_W){1'b0}}, w_digit};
    assign w_mag_new  = (w_mag10 > {{(PROD_W-MAG_W){1'b0}}, MAG_LIMIT}) ?
                        MAG_LIMIT : w_mag10[MAG_W-1:0];

    // next state
    always_comb begin
        n_phase = r_phase;
        n_pos   = r_pos;
        n_dcnt  = r_dcnt;
        n_neg   = r_neg;
        n_x_neg = r_x_neg;
        n_x_mag = r_x_mag;
        n_y_mag = r_y_mag;
        n_err   = r_err;
        if (w_accept && w_is_end) begin
            n_phase = PH_EXPECT_X;
            n_pos   = '0;
            n_dcnt  = '0;
            n_neg   = 1'b0;
            n_x_neg = 1'b0;
            n_x_mag = '0;
            n_y_mag = '0;
            n_err   = 1'b0;
        end else if (w_accept && !w_is_ctrl) begin
            if (r_pos >= POS_LIMIT) begin
                n_err = 1'b1;
            end else begin
                n_pos = r_pos + 1'b1;
                if (!r_err) begin
                    case (r_phase)
                        PH_EXPECT_X: begin
                            if (i_byte == CH_X) begin
                                n_phase = PH_X_SEP;
                            end else begin
                                n_err = 1'b1;
                            end
                        end
                        PH_X_SEP: begin
                            n_phase = PH_X_FIRST;
                        end
                        PH_X_FIRST, PH_X_DIGITS: begin
                            if (i_byte == CH_Y) begin
                                n_x_neg = r_neg;
                                n_neg   = 1'b0;
                                n_dcnt  = '0;
                                n_phase = PH_Y_SEP;
                            end else if (i_byte == CH_MINUS && r_phase == PH_X_FIRST) begin
                                n_neg   = 1'b1;
                                n_phase = PH_X_DIGITS;
                            end else if (w_is_digit) begin
                                n_dcnt  = w_dcnt_inc;
                                n_phase = PH_X_DIGITS;
                                if (w_too_many) begin
                                    n_err = 1'b1;
                                end else begin
                                    n_x_mag = w_mag_new;
                                end
                            end else begin
                                n_err = 1'b1;
                            end
                        end
                        PH_Y_SEP: begin
                            n_phase = PH_Y_FIRST;
                        end
                        PH_Y_FIRST, PH_Y_DIGITS: begin
                            if (i_byte == CH_MINUS && r_phase == PH_Y_FIRST) begin
                                n_neg   = 1'b1;
                                n_phase = PH_Y_DIGITS;
                            end else if (w_is_digit) begin
                                n_dcnt  = w_dcnt_inc;
                                n_phase = PH_Y_DIGITS;
                                if (w_too_many) begin
                                    n_err = 1'b1;
                                end else begin
                                    n_y_mag = w_mag_new;
                                end
                            end else begin
                                n_err = 1'b1;
                            end
                        end
                        default: begin
                            n_err = 1'b1;
                        end
                    endcase
                end
            end
        end
    end

    // outputs: ready while the queue has room, record on ';'
    always_comb begin
        o_byte_ready = !i_q_status.full;
        o_push       = w_accept && w_is_end;
        o_rec.valid  = !r_err && w_in_y;
        o_rec.x_neg  = r_x_neg;
        o_rec.x_mag  = r_x_mag;
        o_rec.y_neg  = r_neg;
        o_rec.y_mag  = r_y_mag;
    end

    // parse state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_EXPECT_X;
            r_pos   <= '0;
            r_dcnt  <= '0;
            r_neg   <= 1'b0;
            r_x_neg <= 1'b0;
            r_x_mag <= '0;
            r_y_mag <= '0;
            r_err   <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_dcnt  <= n_dcnt;
            r_neg   <= n_neg;
            r_x_neg <= n_x_neg;
            r_x_mag <= n_x_mag;
            r_y_mag <= n_y_mag;
            r_err   <= n_err;
        end
    end

endmodule

[hdl/jfdm_queue.sv]
// short first-in first-out queue of parsed frame records
module jfdm_queue
    import jfdm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_frame_rec i_rec,
    input  logic       i_pop,
    output t_frame_rec o_rec,
    output t_q_status  o_status
);

    t_frame_rec          r_slot [QDEPTH];
    logic [QPTR_W-1:0]   r_wptr, n_wptr;
    logic [QPTR_W-1:0]   r_rptr, n_rptr;
    logic [QCNT_W-1:0]   r_count, n_count;

    // pointer and fill count update
    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = (r_rptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // record storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_rec;
        end
    end

    assign o_rec           = r_slot[r_rptr];
    assign o_status.full   = (r_count == QCNT_W'(QDEPTH));
    assign o_status.empty  = (r_count == '0);

endmodule

[hdl/jfdm_back.sv]
// drive mapper: quadrant rules, direction tracking, output register
module jfdm_back
    import jfdm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CFG_AW-1:0]  i_cfg_addr,
    input  logic [LEVEL_W-1:0] i_cfg_wdata,
    input  t_frame_rec         i_rec,
    input  t_q_status          i_q_status,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output t_result            o_result
);

    logic [LEVEL_W-1:0]       r_left_level;
    logic [LEVEL_W-1:0]       r_right_level;
    logic                     r_dir, n_dir;
    logic                     r_out_valid;
    t_result                  r_out, n_out;

    logic signed [SVAL_W-1:0] w_x;
    logic signed [SVAL_W-1:0] w_y;
    logic                     w_use_l;
    logic                     w_use_r;
    logic                     w_set;
    logic                     w_set_bwd;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_level  <= LEVEL_RESET;
            r_right_level <= LEVEL_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_LEFT_LEVEL:  r_left_level  <= i_cfg_wdata;
                CFG_RIGHT_LEVEL: r_right_level <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // signed joystick values
    assign w_x = i_rec.x_neg ? -$signed({2'b00, i_rec.x_mag}) : $signed({2'b00, i_rec.x_mag});
    assign w_y = i_rec.y_neg ? -$signed({2'b00, i_rec.y_mag}) : $signed({2'b00, i_rec.y_mag});

    // quadrant rules, tried in order
    always_comb begin
        w_use_l   = 1'b0;
        w_use_r   = 1'b0;
        w_set     = 1'b0;
        w_set_bwd = 1'b0;
        if (w_x == '0 && w_y == '0) begin
            w_use_l = 1'b0;
        end else if (w_y >= 0 && w_x >= 0) begin
            if (w_y >= w_x) begin
                w_set = 1'b1; w_use_l = 1'b1; w_use_r = 1'b1;
            end else begin
                w_use_r = 1'b1;
            end
        end else if (w_y <= 0 && w_x <= 0) begin
            if (w_x >= w_y) begin
                w_set = 1'b1; w_set_bwd = 1'b1; w_use_l = 1'b1; w_use_r = 1'b1;
            end else begin
                w_use_l = 1'b1;
            end
        end else if (w_y >= 0 && w_x <= 0) begin
            if (-w_x > w_y) begin
                w_use_l = 1'b1;
            end else begin
                w_set = 1'b1; w_use_l = 1'b1; w_use_r = 1'b1;
            end
        end else begin
            if (w_x > -w_y) begin
                w_use_r = 1'b1;
            end else begin
                w_set = 1'b1; w_set_bwd = 1'b1; w_use_l = 1'b1; w_use_r = 1'b1;
            end
        end
    end

    // result of the head record
    always_comb begin
        o_pop = !i_q_status.empty && (!r_out_valid || i_ready);
        n_dir = r_dir;
        n_out = '0;
        n_out.frame_valid = i_rec.valid;
        if (i_rec.valid) begin
            if (w_set) begin
                n_dir = w_set_bwd;
            end
            n_out.left_drive       = w_use_l ? r_left_level : '0;
            n_out.right_drive      = w_use_r ? r_right_level : '0;
            n_out.toggle_direction = w_set && (w_set_bwd != r_dir);
            n_out.brake_request    = (i_rec.x_mag == BRAKE_VALUE) && !i_rec.x_neg
                                   && (i_rec.y_mag == BRAKE_VALUE) && !i_rec.y_neg;
        end
        n_out.direction_backward = n_dir;
    end

    // direction and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_dir       <= n_dir;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= n_out;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

[hdl/joystick_frame_drive_mapper.sv]
// top level of the joystick frame drive mapper
//
//  channel   direction  handshake                      payload
//  s_axis    in         s_axis_tvalid / s_axis_tready  one frame byte
//  m_axis    out        m_axis_tvalid / m_axis_tready  one drive result per ';'
//  cfg       in         i_cfg_we                       drive level registers
//
// one byte per cycle is taken; a ';' reaches m_axis via queue and output register
// the parser only stalls when the two-entry record queue is full
// the mapper stalls on its own when m_axis_tready is low; its output register frees
// the queue in the same cycle the result is taken
// synchronous active-low reset; drive levels reset to 70, direction to forward
`include "joystick_frame_drive_mapper_macros.svh"

module joystick_frame_drive_mapper
    import jfdm_pkg::*;
#(
    parameter int MAX_DIGITS = DEF_MAX_DIGITS,
    parameter int LINE_LIMIT = DEF_LINE_LIMIT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // frame bytes
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [BYTE_W-1:0]  s_axis_tdata,   // [7:0] rx_byte
    // drive results
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // [0] frame_valid, [7:1] left_drive, [14:8] right_drive, [15] direction_backward,
    // [16] toggle_direction, [17] brake_request, [23:18] zero
    output logic [OUT_W-1:0]   m_axis_tdata,
    // configuration writes
    input  logic               i_cfg_we,
    input  logic [CFG_AW-1:0]  i_cfg_addr,
    input  logic [LEVEL_W-1:0] i_cfg_wdata
);

    logic       w_push;
    logic       w_pop;
    t_frame_rec w_rec_in;
    t_frame_rec w_rec_out;
    t_q_status  w_q_status;
    t_result    w_result;

    // parser
    jfdm_front #(
        .MAX_DIGITS (MAX_DIGITS),
        .LINE_LIMIT (LINE_LIMIT)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte_valid (s_axis_tvalid),
        .i_byte       (s_axis_tdata),
        .i_q_status   (w_q_status),
        .o_byte_ready (s_axis_tready),
        .o_push       (w_push),
        .o_rec        (w_rec_in)
    );

    // record queue
    jfdm_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_rec    (w_rec_in),
        .i_pop    (w_pop),
        .o_rec    (w_rec_out),
        .o_status (w_q_status)
    );

    // mapper
    jfdm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_rec       (w_rec_out),
        .i_q_status  (w_q_status),
        .o_pop       (w_pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_result    (w_result)
    );

    // pack the result, zero fill to whole bytes
    assign m_axis_tdata = {{(OUT_W - $bits(t_result)){1'b0}}, w_result};

    // checks
    `JFDM_ASSERT_IMP(a_no_push_when_full, w_push, !w_q_status.full,
        "record pushed into a full queue")
    `JFDM_ASSERT_IMP(a_no_pop_when_empty, w_pop, !w_q_status.empty,
        "record popped from an empty queue")
    `JFDM_ASSERT_IMP(a_invalid_is_quiet, m_axis_tvalid && !w_result.frame_valid,
        w_result.left_drive == '0 && w_result.right_drive == '0 &&
        !w_result.toggle_direction && !w_result.brake_request,
        "invalid frame result carries drive or flags")
    `JFDM_ASSERT_NXT(a_pop_loads_output, w_pop, m_axis_tvalid,
        "popped record did not reach the output")

endmodule
